// File: rtl/core/lsl_pkg.sv
`default_nettype none
package lsl_pkg;

    // name buffer size and derived widths
    localparam int MAX_NAME_CHARS = 8;
    localparam int CNT_W          = $clog2(MAX_NAME_CHARS + 1);
    localparam int IDX_W          = $clog2(MAX_NAME_CHARS);

    // queue between classifier and emitter
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // token kinds
    localparam logic [4:0] K_AND     = 5'd0;
    localparam logic [4:0] K_OR      = 5'd1;
    localparam logic [4:0] K_NOT     = 5'd2;
    localparam logic [4:0] K_DEFINE  = 5'd3;
    localparam logic [4:0] K_RUN     = 5'd4;
    localparam logic [4:0] K_FIND    = 5'd5;
    localparam logic [4:0] K_CLEAR   = 5'd6;
    localparam logic [4:0] K_ALL     = 5'd7;
    localparam logic [4:0] K_NAME    = 5'd8;
    localparam logic [4:0] K_VALUE   = 5'd9;
    localparam logic [4:0] K_LPAREN  = 5'd10;
    localparam logic [4:0] K_RPAREN  = 5'd11;
    localparam logic [4:0] K_COLON   = 5'd12;
    localparam logic [4:0] K_SEMI    = 5'd13;
    localparam logic [4:0] K_QUOTE   = 5'd14;
    localparam logic [4:0] K_COMMA   = 5'd15;
    localparam logic [4:0] K_NEWLINE = 5'd16;
    localparam logic [4:0] K_ERROR   = 5'd17;

    localparam logic [1:0] NO_VALUE  = 2'd2;
    localparam logic [1:0] VAL_ZERO  = 2'd0;
    localparam logic [1:0] VAL_ONE   = 2'd1;

    // keywords packed first character in lowest byte, zero padded
    localparam logic [63:0] W_DEFINE = 64'h0000_454E_4946_4544;
    localparam logic [63:0] W_RUN    = 64'h0000_0000_004E_5552;
    localparam logic [63:0] W_FIND   = 64'h0000_0000_444E_4946;
    localparam logic [63:0] W_CLEAR  = 64'h0000_0052_4145_4C43;
    localparam logic [63:0] W_ALL    = 64'h0000_0000_004C_4C41;
    localparam logic [63:0] W_ONE    = 64'h0000_0000_0000_0031;
    localparam logic [63:0] W_ZERO   = 64'h0000_0000_0000_0030;

    localparam int L_DEFINE = 6;
    localparam int L_RUN    = 3;
    localparam int L_FIND   = 4;
    localparam int L_CLEAR  = 5;
    localparam int L_ALL    = 3;
    localparam int L_DIGIT  = 1;

    // one queued work entry: optional flushed name, then optional own token
    typedef struct packed {
        logic        has_name;
        logic [4:0]  name_kind;
        logic [1:0]  name_value;
        logic [63:0] name_chars;
        logic [3:0]  name_length;
        logic        name_overflow;
        logic        has_tok;
        logic [4:0]  tok_kind;
    } lsl_entry_t;

    // queue status toward the classifier
    typedef struct packed {
        logic full;
    } lsl_qstat_t;

endpackage
`default_nettype wire

// File: rtl/core/lsl_front.sv
`default_nettype none
module lsl_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [7:0]        s_tdata,    // in_byte
    input  wire lsl_pkg::lsl_qstat_t qstat,
    output logic                   push,
    output lsl_pkg::lsl_entry_t    entry
);

    typedef enum logic [2:0] {
        CLS_CHAR,
        CLS_OP,
        CLS_SPACE,
        CLS_DELIM,
        CLS_ERR
    } cls_t;

    logic [7:0]                  buf_reg [lsl_pkg::MAX_NAME_CHARS];
    logic [lsl_pkg::CNT_W-1:0]   count_reg, count_next;
    logic                        ovf_reg, ovf_next;
    logic                        halted_reg, halted_next;

    cls_t        cls;
    logic [4:0]  tkind;
    logic [7:0]  c;
    logic        accept;
    logic [63:0] chars;
    logic        is_def, is_run, is_find, is_clear, is_all, is_one, is_zero;

    assign c        = s_tdata;
    assign s_tready = halted_reg | ~qstat.full;
    assign accept   = s_tvalid & s_tready & ~halted_reg;

    // byte class
    always_comb begin
        cls   = CLS_ERR;
        tkind = lsl_pkg::K_ERROR;
        if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
            (c >= "0" && c <= "9") || c == ".") begin
            cls = CLS_CHAR;
        end else begin
            case (c)
                "&":   begin cls = CLS_OP;    tkind = lsl_pkg::K_AND;     end
                "|":   begin cls = CLS_OP;    tkind = lsl_pkg::K_OR;      end
                "!":   begin cls = CLS_OP;    tkind = lsl_pkg::K_NOT;     end
                " ":   begin cls = CLS_SPACE; tkind = lsl_pkg::K_ERROR;   end
                "(":   begin cls = CLS_DELIM; tkind = lsl_pkg::K_LPAREN;  end
                ")":   begin cls = CLS_DELIM; tkind = lsl_pkg::K_RPAREN;  end
                ":":   begin cls = CLS_DELIM; tkind = lsl_pkg::K_COLON;   end
                ";":   begin cls = CLS_DELIM; tkind = lsl_pkg::K_SEMI;    end
                "\"":  begin cls = CLS_DELIM; tkind = lsl_pkg::K_QUOTE;   end
                ",":   begin cls = CLS_DELIM; tkind = lsl_pkg::K_COMMA;   end
                8'h0A: begin cls = CLS_DELIM; tkind = lsl_pkg::K_NEWLINE; end
                default: begin cls = CLS_ERR; tkind = lsl_pkg::K_ERROR;   end
            endcase
        end
    end

    // pending name, bytes past the count masked to zero
    always_comb begin
        chars = '0;
        for (int i = 0; i < lsl_pkg::MAX_NAME_CHARS; i++) begin
            if (i < int'(count_reg)) begin
                chars[8*i +: 8] = buf_reg[i];
            end
        end
    end

    // keyword and value compares
    always_comb begin
        is_def   = ~ovf_reg && count_reg == lsl_pkg::CNT_W'(lsl_pkg::L_DEFINE)
                   && chars == lsl_pkg::W_DEFINE;
        is_run   = ~ovf_reg && count_reg == lsl_pkg::CNT_W'(lsl_pkg::L_RUN)
                   && chars == lsl_pkg::W_RUN;
        is_find  = ~ovf_reg && count_reg == lsl_pkg::CNT_W'(lsl_pkg::L_FIND)
                   && chars == lsl_pkg::W_FIND;
        is_clear = ~ovf_reg && count_reg == lsl_pkg::CNT_W'(lsl_pkg::L_CLEAR)
                   && chars == lsl_pkg::W_CLEAR;
        is_all   = ~ovf_reg && count_reg == lsl_pkg::CNT_W'(lsl_pkg::L_ALL)
                   && chars == lsl_pkg::W_ALL;
        is_one   = ~ovf_reg && count_reg == lsl_pkg::CNT_W'(lsl_pkg::L_DIGIT)
                   && chars == lsl_pkg::W_ONE;
        is_zero  = ~ovf_reg && count_reg == lsl_pkg::CNT_W'(lsl_pkg::L_DIGIT)
                   && chars == lsl_pkg::W_ZERO;
    end

    // queue entry for this byte
    always_comb begin
        entry               = '0;
        entry.name_value    = lsl_pkg::NO_VALUE;
        entry.name_kind     = lsl_pkg::K_NAME;
        entry.has_name      = (cls == CLS_SPACE || cls == CLS_DELIM) && count_reg != '0;
        entry.has_tok       = (cls == CLS_OP || cls == CLS_DELIM || cls == CLS_ERR);
        entry.tok_kind      = tkind;
        if (is_def) begin
            entry.name_kind = lsl_pkg::K_DEFINE;
        end else if (is_run) begin
            entry.name_kind = lsl_pkg::K_RUN;
        end else if (is_find) begin
            entry.name_kind = lsl_pkg::K_FIND;
        end else if (is_clear) begin
            entry.name_kind = lsl_pkg::K_CLEAR;
        end else if (is_all) begin
            entry.name_kind = lsl_pkg::K_ALL;
        end else if (is_one) begin
            entry.name_kind  = lsl_pkg::K_VALUE;
            entry.name_value = lsl_pkg::VAL_ONE;
        end else if (is_zero) begin
            entry.name_kind  = lsl_pkg::K_VALUE;
            entry.name_value = lsl_pkg::VAL_ZERO;
        end else begin
            entry.name_chars    = chars;
            entry.name_length   = 4'(count_reg);
            entry.name_overflow = ovf_reg;
        end
    end

    assign push = accept && (entry.has_name || entry.has_tok);

    // buffer state update
    always_comb begin
        count_next  = count_reg;
        ovf_next    = ovf_reg;
        halted_next = halted_reg;
        if (accept) begin
            case (cls)
                CLS_CHAR: begin
                    if (count_reg < lsl_pkg::CNT_W'(lsl_pkg::MAX_NAME_CHARS)) begin
                        count_next = count_reg + 1'b1;
                    end else begin
                        ovf_next = 1'b1;
                    end
                end
                CLS_SPACE, CLS_DELIM: begin
                    count_next = '0;
                    ovf_next   = 1'b0;
                end
                CLS_ERR: halted_next = 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            ovf_reg    <= 1'b0;
            halted_reg <= 1'b0;
        end else begin
            count_reg  <= count_next;
            ovf_reg    <= ovf_next;
            halted_reg <= halted_next;
        end
    end

    // character store
    always_ff @(posedge aclk) begin
        if (accept && cls == CLS_CHAR &&
            count_reg < lsl_pkg::CNT_W'(lsl_pkg::MAX_NAME_CHARS)) begin
            buf_reg[count_reg[lsl_pkg::IDX_W-1:0]] <= c;
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/lsl_queue.sv
`default_nettype none
module lsl_queue (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                push,
    input  wire lsl_pkg::lsl_entry_t push_entry,
    output lsl_pkg::lsl_qstat_t      qstat,
    output logic                     head_valid,
    output lsl_pkg::lsl_entry_t      head_entry,
    input  wire logic                pop
);

    lsl_pkg::lsl_entry_t        mem_reg [lsl_pkg::QDEPTH];
    logic [lsl_pkg::QPTR_W-1:0] wptr_reg, wptr_next;
    logic [lsl_pkg::QPTR_W-1:0] rptr_reg, rptr_next;
    logic [lsl_pkg::QCNT_W-1:0] cnt_reg, cnt_next;

    assign qstat.full = cnt_reg == lsl_pkg::QCNT_W'(lsl_pkg::QDEPTH);
    assign head_valid = cnt_reg != '0;
    assign head_entry = mem_reg[rptr_reg];

    // pointer and fill update
    always_comb begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (push) begin
            wptr_next = (wptr_reg == lsl_pkg::QPTR_W'(lsl_pkg::QDEPTH - 1)) ? '0
                        : wptr_reg + 1'b1;
        end
        if (pop) begin
            rptr_next = (rptr_reg == lsl_pkg::QPTR_W'(lsl_pkg::QDEPTH - 1)) ? '0
                        : rptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    // entry store
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wptr_reg] <= push_entry;
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/lsl_back.sv
`default_nettype none
module lsl_back (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                head_valid,
    input  wire lsl_pkg::lsl_entry_t head_entry,
    output logic                     pop,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [79:0]              m_tdata,
    output logic                     m_tlast
);

    logic        valid_reg, valid_next;
    logic        phase_reg, phase_next;
    logic [4:0]  kind_reg, kind_next;
    logic [1:0]  value_reg, value_next;
    logic [63:0] chars_reg, chars_next;
    logic [3:0]  len_reg, len_next;
    logic        ovf_reg, ovf_next;
    logic        last_reg, last_next;
    logic        load;

    assign load = head_valid && (!valid_reg || m_tready);

    // pick the next beat from the head entry
    always_comb begin
        valid_next = valid_reg;
        phase_next = phase_reg;
        kind_next  = kind_reg;
        value_next = value_reg;
        chars_next = chars_reg;
        len_next   = len_reg;
        ovf_next   = ovf_reg;
        last_next  = last_reg;
        pop        = 1'b0;
        if (valid_reg && m_tready) begin
            valid_next = 1'b0;
        end
        if (load) begin
            valid_next = 1'b1;
            if (head_entry.has_name && !phase_reg) begin
                kind_next  = head_entry.name_kind;
                value_next = head_entry.name_value;
                chars_next = head_entry.name_chars;
                len_next   = head_entry.name_length;
                ovf_next   = head_entry.name_overflow;
                last_next  = !head_entry.has_tok;
                if (head_entry.has_tok) begin
                    phase_next = 1'b1;
                end else begin
                    pop = 1'b1;
                end
            end else begin
                kind_next  = head_entry.tok_kind;
                value_next = lsl_pkg::NO_VALUE;
                chars_next = '0;
                len_next   = '0;
                ovf_next   = 1'b0;
                last_next  = 1'b1;
                phase_next = 1'b0;
                pop        = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

    // output beat payload
    always_ff @(posedge aclk) begin
        kind_reg  <= kind_next;
        value_reg <= value_next;
        chars_reg <= chars_next;
        len_reg   <= len_next;
        ovf_reg   <= ovf_next;
        last_reg  <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {4'b0000, ovf_reg, len_reg, chars_reg, value_reg, kind_reg};

endmodule
`default_nettype wire

// File: rtl/core/logic_script_lexer.sv
// a byte's first token is written into the queue and then into the output register
// throughput, when not stalled: one byte per cycle in, one token beat per cycle out;
//   a byte that flushes a name and has its own token needs two output beats
// a four-entry queue between classifier and emitter absorbs output stalls
// reset: aresetn synchronous active low, clears name count, overflow, halt and queue
`default_nettype none
module logic_script_lexer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [79:0]      m_tdata,   // [4:0] token_kind, [6:5] token_value,
                                        // [70:7] name_chars, [74:71] name_length,
                                        // [75] name_overflow, [79:76] zero
    output logic             m_tlast    // last_of_item
);

    lsl_pkg::lsl_entry_t push_entry;
    lsl_pkg::lsl_entry_t head_entry;
    lsl_pkg::lsl_qstat_t qstat;
    logic                push;
    logic                pop;
    logic                head_valid;

    // classifier and name buffer
    lsl_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .qstat    (qstat),
        .push     (push),
        .entry    (push_entry)
    );

    // work queue
    lsl_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .qstat      (qstat),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop)
    );

    // token emitter
    lsl_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule
`default_nettype wire

// File: rtl/core/lsl_checker.sv
`default_nettype none
module lsl_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [79:0] m_tdata,
    input wire logic        m_tlast
);

    // stalled beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output beat changed while stalled");

    // only name tokens carry name data
    a_name_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[4:0] != lsl_pkg::K_NAME |->
            m_tdata[75:7] == '0)
        else $error("name data on a non-name token");

    // value field agrees with kind
    a_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[4:0] == lsl_pkg::K_VALUE) ?
            (m_tdata[6:5] == lsl_pkg::VAL_ZERO || m_tdata[6:5] == lsl_pkg::VAL_ONE) :
            (m_tdata[6:5] == lsl_pkg::NO_VALUE))
        else $error("token value does not match kind");

    // name tokens are non-empty and within the buffer
    a_name_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[4:0] == lsl_pkg::K_NAME |->
            m_tdata[74:71] != 4'd0 &&
            m_tdata[74:71] <= 4'(lsl_pkg::MAX_NAME_CHARS))
        else $error("name length out of range");

    // nothing offered right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind logic_script_lexer lsl_checker u_lsl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
`default_nettype wire

// File: tb/lexer_token_checker.sv
module lexer_token_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [79:0] m_tdata,   // [4:0] kind, [6:5] value, [70:7] chars,
                                        // [74:71] length, [75] overflow, [79:76] zero
    input  wire logic        m_tlast,   // last token of the input byte
    output int               mismatches,
    output int               tokens_left,
    output int               tokens_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [4:0]  kind;
        logic [1:0]  value;
        logic [63:0] chars;
        logic [3:0]  length;
        logic        overflow;
        logic        is_last;
        logic [3:0]  pad;
    } token_t;

    token_t     token_queue[$];
    logic [7:0] name_buf[lsl_pkg::MAX_NAME_CHARS];
    int         name_cnt;
    bit         name_trunc;
    bit         halted;
    int         err_cnt;
    int         seen_cnt;

    // keyword spelled as the block packs it, first char in the low byte
    function automatic logic [63:0] word_bits(input string w);
        logic [63:0] r;
        r = '0;
        for (int i = 0; i < w.len(); i++) begin
            r[8*i +: 8] = w[i];
        end
        return r;
    endfunction

    task automatic push_token(input logic [4:0] kind, input logic [1:0] value,
                              input logic [63:0] chars, input int length,
                              input bit overflow);
        token_t t;
        t.kind     = kind;
        t.value    = value;
        t.chars    = chars;
        t.length   = 4'(length);
        t.overflow = overflow;
        t.is_last  = 1'b0;
        t.pad      = '0;
        token_queue.insert(token_queue.size(), t);
    endtask

    // pending name becomes a keyword, value or name token
    task automatic flush_name();
        logic [63:0] chars;
        logic [4:0]  kind;
        logic [1:0]  value;
        chars = '0;
        kind  = lsl_pkg::K_NAME;
        value = lsl_pkg::NO_VALUE;
        if (name_cnt != 0) begin
            for (int i = 0; i < name_cnt; i++) begin
                chars[8*i +: 8] = name_buf[i];
            end
            // a truncated name never matches a keyword
            if (!name_trunc) begin
                if (chars == word_bits("DEFINE")) kind = lsl_pkg::K_DEFINE;
                else if (chars == word_bits("RUN")) kind = lsl_pkg::K_RUN;
                else if (chars == word_bits("FIND")) kind = lsl_pkg::K_FIND;
                else if (chars == word_bits("CLEAR")) kind = lsl_pkg::K_CLEAR;
                else if (chars == word_bits("ALL")) kind = lsl_pkg::K_ALL;
                else if (chars == word_bits("1")) begin
                    kind  = lsl_pkg::K_VALUE;
                    value = lsl_pkg::VAL_ONE;
                end else if (chars == word_bits("0")) begin
                    kind  = lsl_pkg::K_VALUE;
                    value = lsl_pkg::VAL_ZERO;
                end
            end
            if (kind == lsl_pkg::K_NAME) begin
                push_token(lsl_pkg::K_NAME, lsl_pkg::NO_VALUE, chars, name_cnt, name_trunc);
            end else begin
                push_token(kind, value, '0, 0, 1'b0);
            end
        end
        name_cnt   = 0;
        name_trunc = 1'b0;
    endtask

    // tokens caused by one input byte
    task automatic lex_byte(input logic [7:0] c);
        int         start_size;
        bit         has_delim;
        logic [4:0] delim;
        start_size = token_queue.size();
        has_delim  = 1'b0;
        delim      = lsl_pkg::K_ERROR;
        if (halted) return;
        if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
            (c >= "0" && c <= "9") || c == ".") begin
            if (name_cnt < lsl_pkg::MAX_NAME_CHARS) begin
                name_buf[name_cnt] = c;
                name_cnt++;
            end else begin
                name_trunc = 1'b1;
            end
            return;
        end
        case (c)
            "&": push_token(lsl_pkg::K_AND, lsl_pkg::NO_VALUE, '0, 0, 1'b0);
            "|": push_token(lsl_pkg::K_OR, lsl_pkg::NO_VALUE, '0, 0, 1'b0);
            "!": push_token(lsl_pkg::K_NOT, lsl_pkg::NO_VALUE, '0, 0, 1'b0);
            " ": flush_name();
            "(": begin has_delim = 1'b1; delim = lsl_pkg::K_LPAREN; end
            ")": begin has_delim = 1'b1; delim = lsl_pkg::K_RPAREN; end
            ":": begin has_delim = 1'b1; delim = lsl_pkg::K_COLON; end
            ";": begin has_delim = 1'b1; delim = lsl_pkg::K_SEMI; end
            "\"": begin has_delim = 1'b1; delim = lsl_pkg::K_QUOTE; end
            ",": begin has_delim = 1'b1; delim = lsl_pkg::K_COMMA; end
            "\n": begin has_delim = 1'b1; delim = lsl_pkg::K_NEWLINE; end
            default: begin
                push_token(lsl_pkg::K_ERROR, lsl_pkg::NO_VALUE, '0, 0, 1'b0);
                halted = 1'b1;
            end
        endcase
        if (has_delim) begin
            flush_name();
            push_token(delim, lsl_pkg::NO_VALUE, '0, 0, 1'b0);
        end
        if (token_queue.size() > start_size) begin
            token_queue[token_queue.size() - 1].is_last = 1'b1;
        end
    endtask

    task automatic check_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            err_cnt++;
            $display("%0t: token %0d field %s mismatch, expected %0h, got %0h",
                     $time, seen_cnt, field, want, got);
        end
    endtask

    // compare output beats first, then predict from the input beat
    always @(posedge aclk) begin : watch
        token_t want;
        if (!aresetn) begin
            token_queue.delete();
            name_cnt   = 0;
            name_trunc = 1'b0;
            halted     = 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (token_queue.size() == 0) begin
                    err_cnt++;
                    $display("%0t: unexpected token beat, expected none, got %h last %b",
                             $time, m_tdata, m_tlast);
                end else begin
                    want = token_queue.pop_front();
                    check_field("kind", 64'(want.kind), 64'(m_tdata[4:0]));
                    check_field("value", 64'(want.value), 64'(m_tdata[6:5]));
                    check_field("chars", want.chars, m_tdata[70:7]);
                    check_field("length", 64'(want.length), 64'(m_tdata[74:71]));
                    check_field("overflow", 64'(want.overflow), 64'(m_tdata[75]));
                    check_field("pad", 64'(want.pad), 64'(m_tdata[79:76]));
                    check_field("last", 64'(want.is_last), 64'(m_tlast));
                end
                seen_cnt++;
            end
            if (s_tvalid && s_tready) lex_byte(s_tdata);
        end
        mismatches  <= err_cnt;
        tokens_left <= token_queue.size();
        tokens_seen <= seen_cnt;
    end

endmodule

// File: tb/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_ITEMS  = 250;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata  = '0;
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [79:0] m_tdata;
    logic        m_tlast;

    int idle_pct     = 0;
    int stall_pct    = 0;
    int bytes_sent   = 0;
    int quiet_cycles = 0;
    int fail_count;
    int tokens_left;
    int tokens_seen;

    logic_script_lexer u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    lexer_token_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .mismatches  (fail_count),
        .tokens_left (tokens_left),
        .tokens_seen (tokens_seen)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // token sink with random back-pressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // watchdog on cycles without any beat
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, quiet_cycles);
            $display("[logic_script_lexer] ERROR");
            $finish;
        end
    end

    // one input beat, with optional idle cycles ahead of it
    task automatic send_byte(input logic [7:0] b);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
    endtask

    function automatic logic [7:0] rand_name_char();
        int r;
        r = $urandom_range(62);
        if (r < 26) return 8'("A" + r);
        if (r < 52) return 8'("a" + r - 26);
        if (r < 62) return 8'("0" + r - 52);
        return ".";
    endfunction

    // delimiters and operators, space weighted up
    function automatic logic [7:0] rand_sep();
        case ($urandom_range(13))
            0, 1, 2: return " ";
            3:  return "(";
            4:  return ")";
            5:  return ",";
            6:  return "\"";
            7:  return ":";
            8:  return ";";
            9:  return "\n";
            10: return "&";
            11: return "|";
            default: return "!";
        endcase
    endfunction

    task automatic send_word(input string w);
        for (int i = 0; i < w.len(); i++) begin
            // operators inside a name leave the buffer alone
            if ($urandom_range(19) == 0) send_byte("&" + 8'($urandom_range(1)) * 8'd86);
            send_byte(w[i]);
        end
    endtask

    // mostly a word followed by separators, sometimes a stray byte
    task automatic send_piece();
        string kw;
        int    n;
        if ($urandom_range(99) < 80) begin
            case ($urandom_range(5))
                0: kw = "DEFINE";
                1: kw = "RUN";
                2: kw = "FIND";
                3: kw = "CLEAR";
                4: kw = "ALL";
                default: kw = $urandom_range(1) ? "1" : "0";
            endcase
            case ($urandom_range(9))
                0, 1, 2: send_word(kw);
                3: send_word(kw.tolower());
                4: send_word(kw.substr(0, kw.len() - 2));
                5: begin
                    send_word(kw);
                    send_byte(rand_name_char());
                end
                default: begin
                    n = ($urandom_range(3) == 0) ? $urandom_range(8, 12) : $urandom_range(1, 8);
                    repeat (n) send_byte(rand_name_char());
                end
            endcase
            n = $urandom_range(1, 2);
            repeat (n) send_byte(rand_sep());
        end else begin
            send_byte($urandom_range(1) ? rand_name_char() : rand_sep());
        end
    endtask

    initial begin : stimulus
        string directed;
        int    base;
        directed = "ALL(1|0)&!z.Z09Aaaa;\" :,\n";
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // operators inside a name, long name, space with nothing pending
        for (int i = 0; i < directed.len(); i++) send_byte(directed[i]);

        // free-running, sender gaps, sink stalls, both
        base = bytes_sent;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 62; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 62; end
                default: begin idle_pct = 14; stall_pct = 14; end
            endcase
            while (bytes_sent < base + PHASE_ITEMS * (phase + 1)) send_piece();
        end

        // unknown byte halts the block, later bytes must be dropped
        idle_pct  = 0;
        stall_pct = 0;
        send_byte(8'($urandom_range(128, 255)));
        repeat (4) send_byte(8'($urandom_range(255)));
        s_tvalid <= 1'b0;

        while (tokens_left != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d input bytes, %0d tokens checked, four gap and stall mixes",
                 bytes_sent, tokens_seen);
        $display("directed operators, long names and keywords, ending in a halt");
        if (fail_count == 0) begin
            $display("[logic_script_lexer] OK");
        end else begin
            $display("[logic_script_lexer] ERROR");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/lsl_pkg.sv
rtl/core/lsl_front.sv
rtl/core/lsl_queue.sv
rtl/core/lsl_back.sv
rtl/core/logic_script_lexer.sv
rtl/core/lsl_checker.sv
tb/lexer_token_checker.sv
tb/tb.sv
